// File: sv/sgu_pkg.sv
// Shared types, codes and tables of the six-channel sound generator.
package sgu_pkg;

  localparam logic [1:0] OP_SELECT = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [4:0] REG_AMP_LAST = 5'd5;
  localparam logic [4:0] REG_OFF_LO   = 5'd8;
  localparam logic [4:0] REG_OFF_HI   = 5'd13;
  localparam logic [4:0] REG_OCT_LO   = 5'd16;
  localparam logic [4:0] REG_OCT_HI   = 5'd18;
  localparam logic [4:0] REG_TONE_EN  = 5'd20;
  localparam logic [4:0] REG_NOISE_EN = 5'd21;
  localparam logic [4:0] REG_NOISE    = 5'd22;
  localparam logic [4:0] REG_ENV0     = 5'd24;
  localparam logic [4:0] REG_ENV1     = 5'd25;
  localparam logic [4:0] REG_CTRL     = 5'd28;

  localparam logic CFG_CLOCK_STEP = 1'b0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] bus_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] left_sample;
    logic [7:0] right_sample;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_BUS, ST_NADD, ST_NSUB, ST_TADD,
    ST_TCHK, ST_TMUL, ST_TEDGE, ST_TMIX, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_BUS, CMD_NADD, CMD_NSUB, CMD_TADD,
    CMD_TCHK, CMD_TMUL, CMD_TEDGE, CMD_TMIX, CMD_DONE
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] ch;
    logic       nidx;
  } ctl_t;

  typedef struct packed {
    logic tick_run;
    logic noise_more;
    logic edge_hit;
    logic out_free;
  } sts_t;

  localparam logic [7:0] PDM_AMP [8][16] = '{
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd4, 8'd4, 8'd8, 8'd8, 8'd12, 8'd12, 8'd16,
      8'd16, 8'd20, 8'd20, 8'd24, 8'd24, 8'd28, 8'd28, 8'd32},
    '{8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
      8'd32, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52, 8'd56, 8'd60},
    '{8'd0, 8'd8, 8'd12, 8'd20, 8'd24, 8'd32, 8'd36, 8'd44,
      8'd48, 8'd56, 8'd60, 8'd68, 8'd72, 8'd80, 8'd84, 8'd92},
    '{8'd0, 8'd8, 8'd16, 8'd24, 8'd32, 8'd40, 8'd48, 8'd56,
      8'd64, 8'd72, 8'd80, 8'd88, 8'd96, 8'd104, 8'd112, 8'd120},
    '{8'd0, 8'd12, 8'd20, 8'd32, 8'd40, 8'd52, 8'd60, 8'd72,
      8'd80, 8'd92, 8'd100, 8'd112, 8'd120, 8'd132, 8'd140, 8'd152},
    '{8'd0, 8'd12, 8'd24, 8'd36, 8'd48, 8'd60, 8'd72, 8'd84,
      8'd96, 8'd108, 8'd120, 8'd132, 8'd144, 8'd156, 8'd168, 8'd180},
    '{8'd0, 8'd16, 8'd28, 8'd44, 8'd56, 8'd72, 8'd84, 8'd100,
      8'd112, 8'd128, 8'd140, 8'd156, 8'd168, 8'd184, 8'd196, 8'd212}
  };

endpackage

// File: sv/sgu_ctrl.sv
// Sequencer of the sound generator: steps the datapath through one request.
module sgu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sgu_pkg::sts_t sts_i,
  output sgu_pkg::ctl_t ctl_o
);
  import sgu_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] ch_q, ch_d;
  logic       n_q, n_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= 3'd0;
      n_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      n_q     <= n_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    n_d     = n_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DISP;
      ST_DISP: begin
        n_d     = 1'b0;
        ch_d    = 3'd0;
        state_d = sts_i.tick_run ? ST_NADD : ST_BUS;
      end
      ST_BUS:   if (sts_i.out_free) state_d = ST_IDLE;
      ST_NADD:  state_d = ST_NSUB;
      ST_NSUB: begin
        if (!sts_i.noise_more) begin
          if (!n_q) begin
            n_d     = 1'b1;
            state_d = ST_NADD;
          end else begin
            state_d = ST_TADD;
          end
        end
      end
      ST_TADD:  state_d = ST_TCHK;
      ST_TCHK:  state_d = sts_i.edge_hit ? ST_TMUL : ST_TMIX;
      ST_TMUL:  state_d = ST_TEDGE;
      ST_TEDGE: state_d = ST_TCHK;
      ST_TMIX: begin
        if (ch_q == 3'd5) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + 3'd1;
          state_d = ST_TADD;
        end
      end
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.cmd  = CMD_NONE;
    ctl_o.ch   = ch_q;
    ctl_o.nidx = n_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) ctl_o.cmd = CMD_LOAD;
      ST_BUS:   if (sts_i.out_free) ctl_o.cmd = CMD_BUS;
      ST_NADD:  ctl_o.cmd = CMD_NADD;
      ST_NSUB:  if (sts_i.noise_more) ctl_o.cmd = CMD_NSUB;
      ST_TADD:  ctl_o.cmd = CMD_TADD;
      ST_TCHK:  ctl_o.cmd = CMD_TCHK;
      ST_TMUL:  ctl_o.cmd = CMD_TMUL;
      ST_TEDGE: ctl_o.cmd = CMD_TEDGE;
      ST_TMIX:  ctl_o.cmd = CMD_TMIX;
      ST_DONE:  if (sts_i.out_free) ctl_o.cmd = CMD_DONE;
      default:  ctl_o.cmd = CMD_NONE;
    endcase
  end

endmodule

// File: sv/sgu_datapath.sv
// Generator state, bus decode, noise, tone, envelope and mixing datapath.
module sgu_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [17:0]       cfg_data_i,
  input  sgu_pkg::in_item_t in_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output sgu_pkg::out_item_t out_data_o,
  input  sgu_pkg::ctl_t     ctl_i,
  output sgu_pkg::sts_t     sts_o
);
  import sgu_pkg::*;

  typedef struct packed {
    logic       en;
    logic       ended;
    logic       res3;
    logic       inv;
    logic       ext;
    logic [2:0] shape;
    logic [4:0] pos;
    logic       ph;
    logic [7:0] lev;
    logic       bpend;
    logic [7:0] bdata;
  } env_t;

  localparam env_t ENV_RST = '{ended: 1'b1, default: '0};

  function automatic logic [3:0] shp_lev(logic [2:0] sh, logic ph, logic [3:0] p);
    logic [3:0] r;
    case (sh) inside
      3'd0:       r = 4'd0;
      3'd1:       r = 4'hF;
      3'd2, 3'd3: r = ph ? 4'd0 : 4'hF - p;
      3'd4, 3'd5: r = ph ? 4'hF - p : p;
      default:    r = ph ? 4'd0 : p;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] env_lev(env_t s);
    logic [3:0] l, t;
    t = s.res3 ? 4'd14 : 4'd15;
    if (s.ended && !s.shape[0]) l = 4'd0;
    else l = shp_lev(s.shape, s.ph, s.pos[3:0]);
    if (s.res3) l = l & 4'hE;
    return {(s.inv ? t - l : l), l};
  endfunction

  function automatic env_t env_new(env_t s, logic [7:0] d);
    env_t r;
    r       = s;
    r.shape = d[3:1];
    r.inv   = d[0];
    r.ext   = d[5];
    r.res3  = d[4];
    r.en    = d[7];
    r.ended = !d[7];
    r.pos   = 5'd0;
    r.ph    = 1'b0;
    r.lev   = env_lev(r);
    return r;
  endfunction

  function automatic env_t env_tick(env_t s);
    env_t       r;
    logic [5:0] p;
    logic [1:0] ph2;
    logic       bnd;
    r   = s;
    bnd = 1'b0;
    p   = {1'b0, s.pos};
    ph2 = {1'b0, s.ph};
    if (!s.en) begin
      r.ended = 1'b1;
      r.pos   = 5'd0;
      r.ph    = 1'b0;
    end else if (!s.ended) begin
      p = {1'b0, s.pos} + (s.res3 ? 6'd2 : 6'd1);
      if (p >= 6'd16) begin
        if (ph2 + 2'd1 == ((s.shape == 3'd4 || s.shape == 3'd5) ? 2'd2 : 2'd1)) begin
          bnd = 1'b1;
          ph2 = 2'd0;
          if (!s.shape[0]) r.ended = 1'b1;
          else p = p - 6'd16;
        end else begin
          ph2 = ph2 + 2'd1;
          p   = p - 6'd16;
        end
      end
      r.pos = p[4:0];
      r.ph  = ph2[0];
      if (s.bpend && bnd) begin
        r.bpend = 1'b0;
        r       = env_new(r, s.bdata);
      end else begin
        r.lev = env_lev(r);
      end
    end
    return r;
  endfunction

  function automatic env_t env_wr(env_t s, logic [7:0] d);
    env_t r;
    r = s;
    if (!d[7]) begin
      if (s.en) begin
        r.en    = 1'b0;
        r.ended = 1'b1;
      end
    end else begin
      r.en = 1'b1;
      if (!s.res3 && d[4]) r.pos = s.pos & 5'h0E;
      else if (s.res3 && !d[4]) r.pos = s.pos | 5'h01;
      r.res3 = d[4];
      if (r.ended) begin
        r       = env_new(r, d);
        r.bpend = 1'b0;
      end else begin
        r.lev   = env_lev(r);
        r.bpend = 1'b1;
        r.bdata = d;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] lfsr(logic [31:0] s);
    return s[0] ? ((s >> 1) ^ 32'h0002_0400) : (s >> 1);
  endfunction

  function automatic logic [7:0] sat(logic [11:0] s);
    logic [12:0] t;
    t = {1'b0, s} + 13'd8;
    return (t[12:4] > 9'd255) ? 8'hFF : t[11:4];
  endfunction

  // control and generator state
  logic [17:0] clk_step_q, clk_step_d, edge_scale_q, edge_scale_d;
  logic [7:0]  reg_q [32];
  logic [7:0]  reg_d [32];
  logic [4:0]  sel_q, sel_d;
  logic        out_on_q, out_on_d, sync_q, sync_d;
  logic [26:0] phase_q [6];
  logic [26:0] phase_d [6];
  logic [5:0]  level_q, level_d;
  logic [8:0]  period_q [6];
  logic [8:0]  period_d [6];
  logic [2:0]  oct_now_q [6];
  logic [2:0]  oct_now_d [6];
  logic [2:0]  oct_nxt_q [6];
  logic [2:0]  oct_nxt_d [6];
  logic [7:0]  off_now_q [6];
  logic [7:0]  off_now_d [6];
  logic [7:0]  off_nxt_q [6];
  logic [7:0]  off_nxt_d [6];
  logic [5:0]  pend_new_q, pend_new_d, pend_def_q, pend_def_d;
  logic [7:0]  amps_q [6];
  logic [7:0]  amps_d [6];
  logic [1:0]  mix_q [6];
  logic [1:0]  mix_d [6];
  logic [1:0]  nsel_q [2];
  logic [1:0]  nsel_d [2];
  logic [18:0] ncnt_q [2];
  logic [18:0] ncnt_d [2];
  logic [31:0] nshift_q [2];
  logic [31:0] nshift_d [2];
  env_t        env_q [2];
  env_t        env_d [2];
  logic        pend_q, pend_d, out_valid_q, out_valid_d;

  // working registers
  in_item_t    item_q, item_d;
  logic [16:0] acc_q, acc_d, tprev_q, tprev_d;
  logic [2:0]  oct_q, oct_d;
  logic [26:0] mula_q, mula_d;
  logic [28:0] rem_q, rem_d;
  logic [17:0] mid_q, mid_d;
  logic [8:0]  pl_q, pl_d, pr_q, pr_d;
  logic [11:0] suml_q, suml_d, sumr_q, sumr_d;
  out_item_t   out_q, out_d;

  logic [2:0]  ch;
  logic        nx, g, eidx;
  logic [26:0] perw, sub, inc;
  logic [18:0] lim;
  logic [44:0] prod;
  logic [16:0] tf, tone_v;
  logic [17:0] inv;
  logic [25:0] ml, mr;
  logic [11:0] suml_n, sumr_n;
  logic [7:0]  d;
  logic [2:0]  c, o;

  assign ch   = ctl_i.ch;
  assign nx   = ctl_i.nidx;
  assign g    = (ch >= 3'd3);
  assign d    = item_q.bus_byte;
  assign perw = {2'b00, period_q[ch], 16'h0000};
  assign sub  = phase_q[ch] - perw;
  assign inc  = {9'd0, clk_step_q} << oct_now_q[ch];
  assign lim  = 19'h1_0000 << nsel_q[nx];
  assign prod = 45'(mula_q) * 45'(edge_scale_q);

  assign sts_o.tick_run   = (item_q.opcode == OP_TICK) && out_on_q && !sync_q;
  assign sts_o.noise_more = (nsel_q[nx] != 2'd3) && (ncnt_q[nx] >= lim);
  assign sts_o.edge_hit   = (phase_q[ch] >= perw);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  always_comb begin
    clk_step_d   = clk_step_q;
    edge_scale_d = edge_scale_q;
    reg_d        = reg_q;
    sel_d        = sel_q;
    out_on_d     = out_on_q;
    sync_d       = sync_q;
    phase_d      = phase_q;
    level_d      = level_q;
    period_d     = period_q;
    oct_now_d    = oct_now_q;
    oct_nxt_d    = oct_nxt_q;
    off_now_d    = off_now_q;
    off_nxt_d    = off_nxt_q;
    pend_new_d   = pend_new_q;
    pend_def_d   = pend_def_q;
    amps_d       = amps_q;
    mix_d        = mix_q;
    nsel_d       = nsel_q;
    ncnt_d       = ncnt_q;
    nshift_d     = nshift_q;
    env_d        = env_q;
    item_d       = item_q;
    acc_d        = acc_q;
    tprev_d      = tprev_q;
    oct_d        = oct_q;
    mula_d       = mula_q;
    rem_d        = rem_q;
    mid_d        = mid_q;
    pl_d         = pl_q;
    pr_d         = pr_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    suml_n       = suml_q + (pend_q ? 12'(pl_q) : 12'd0);
    sumr_n       = sumr_q + (pend_q ? 12'(pr_q) : 12'd0);
    suml_d       = suml_n;
    sumr_d       = sumr_n;
    pend_d       = 1'b0;
    eidx         = 1'b0;
    c            = 3'd0;
    o            = 3'd0;
    tf           = 17'd0;
    tone_v       = 17'd0;
    inv          = 18'd0;
    ml           = 26'd0;
    mr           = 26'd0;

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_CLOCK_STEP) clk_step_d = cfg_data_i;
      else edge_scale_d = cfg_data_i;
    end

    case (ctl_i.cmd)
      CMD_LOAD: begin
        item_d = in_data_i;
        suml_d = 12'd0;
        sumr_d = 12'd0;
      end
      CMD_BUS: begin
        out_valid_d = 1'b1;
        out_d       = '0;
        case (item_q.opcode)
          OP_SELECT: begin
            sel_d = d[4:0];
            eidx  = d[0];
            if ((d[4:0] == REG_ENV0 || d[4:0] == REG_ENV1) &&
                env_q[eidx].ext && env_q[eidx].en) begin
              env_d[eidx] = env_tick(env_q[eidx]);
            end
          end
          OP_WRITE: begin
            reg_d[sel_q] = d;
            if (sel_q <= REG_AMP_LAST) begin
              amps_d[sel_q[2:0]] = d;
            end else if (sel_q >= REG_OFF_LO && sel_q <= REG_OFF_HI) begin
              c = sel_q[2:0];
              off_nxt_d[c] = d;
              if (!sync_q) begin
                pend_new_d[c] = 1'b1;
                if (oct_nxt_q[c] == oct_now_q[c]) pend_def_d[c] = 1'b1;
              end else begin
                oct_now_d[c]  = oct_nxt_q[c];
                off_now_d[c]  = d;
                period_d[c]   = 9'd511 - {1'b0, d};
                pend_new_d[c] = 1'b0;
                pend_def_d[c] = 1'b0;
              end
            end else if (sel_q >= REG_OCT_LO && sel_q <= REG_OCT_HI) begin
              for (int i = 0; i < 2; i++) begin
                c = {sel_q[1:0], 1'(i)};
                o = (i == 1) ? d[6:4] : d[2:0];
                oct_nxt_d[c]  = o;
                pend_new_d[c] = 1'b1;
                pend_def_d[c] = 1'b0;
                if (sync_q) begin
                  oct_now_d[c]  = o;
                  off_now_d[c]  = off_nxt_q[c];
                  period_d[c]   = 9'd511 - {1'b0, off_nxt_q[c]};
                  pend_new_d[c] = 1'b0;
                end
              end
            end else if (sel_q == REG_TONE_EN || sel_q == REG_NOISE_EN) begin
              for (int i = 0; i < 6; i++) mix_d[i][sel_q[0]] = d[i];
            end else if (sel_q == REG_NOISE) begin
              nsel_d[0] = d[1:0];
              nsel_d[1] = d[5:4];
            end else if (sel_q == REG_ENV0 || sel_q == REG_ENV1) begin
              env_d[sel_q[0]] = env_wr(env_q[sel_q[0]], d);
            end else if (sel_q == REG_CTRL) begin
              if (d[1] && !sync_q) begin
                for (int i = 0; i < 6; i++) begin
                  phase_d[i]    = 27'd0;
                  level_d[i]    = 1'b1;
                  oct_now_d[i]  = oct_nxt_q[i];
                  off_now_d[i]  = off_nxt_q[i];
                  period_d[i]   = 9'd511 - {1'b0, off_nxt_q[i]};
                  pend_new_d[i] = 1'b0;
                  pend_def_d[i] = 1'b0;
                end
                ncnt_d[0] = 19'd0;
                ncnt_d[1] = 19'd0;
              end
              sync_d   = d[1];
              out_on_d = d[0];
            end
          end
          OP_READ: out_d.read_data = reg_q[sel_q];
          default: ;
        endcase
      end
      CMD_NADD: begin
        if (nsel_q[nx] != 2'd3) ncnt_d[nx] = ncnt_q[nx] + {1'b0, clk_step_q};
      end
      CMD_NSUB: begin
        ncnt_d[nx]   = ncnt_q[nx] - lim;
        nshift_d[nx] = lfsr(nshift_q[nx]);
      end
      CMD_TADD: begin
        phase_d[ch] = phase_q[ch] + inc;
        oct_d       = oct_now_q[ch];
        acc_d       = 17'd0;
        tprev_d     = 17'd0;
      end
      CMD_TCHK: begin
        if (sts_o.edge_hit) begin
          phase_d[ch] = sub;
          mula_d      = sub >> oct_q;
        end else begin
          phase_d[ch] = {1'b0, phase_q[ch][25:0]};
          tone_v = acc_q + (level_q[ch] ? (17'h1_0000 - tprev_q) : 17'd0);
          case (mix_q[ch])
            2'd1:    mid_d = {tone_v, 1'b0};
            2'd2:    mid_d = nshift_q[g][0] ? 18'h2_0000 : 18'd0;
            2'd3:    mid_d = nshift_q[g][0] ? {1'b0, tone_v} : {tone_v, 1'b0};
            default: mid_d = 18'd0;
          endcase
        end
      end
      CMD_TMUL: rem_d = prod[44:16];
      CMD_TEDGE: begin
        tf = (rem_q >= 29'h1_0000) ? 17'd0 : 17'h1_0000 - rem_q[16:0];
        if (tf < tprev_q) tf = tprev_q;
        if (level_q[ch]) acc_d = acc_q + (tf - tprev_q);
        tprev_d     = tf;
        level_d[ch] = ~level_q[ch];
        if (ch == 3'd0 && nsel_q[0] == 2'd3) nshift_d[0] = lfsr(nshift_q[0]);
        if (ch == 3'd3 && nsel_q[1] == 2'd3) nshift_d[1] = lfsr(nshift_q[1]);
        if (ch == 3'd1 && env_q[0].en && !env_q[0].ext) env_d[0] = env_tick(env_q[0]);
        if (ch == 3'd4 && env_q[1].en && !env_q[1].ext) env_d[1] = env_tick(env_q[1]);
        if (pend_new_q[ch]) begin
          oct_now_d[ch] = oct_nxt_q[ch];
          if (!pend_def_q[ch]) begin
            off_now_d[ch]  = off_nxt_q[ch];
            pend_new_d[ch] = 1'b0;
            period_d[ch]   = 9'd511 - {1'b0, off_nxt_q[ch]};
          end else begin
            period_d[ch]   = 9'd511 - {1'b0, off_now_q[ch]};
          end
          pend_def_d[ch] = 1'b0;
        end
      end
      CMD_TMIX: begin
        pend_d = 1'b1;
        if ((ch == 3'd2 || ch == 3'd5) && env_q[g].en) begin
          inv  = 18'h2_0000 - mid_q;
          ml   = 26'(PDM_AMP[amps_q[ch][3:1]][env_q[g].lev[3:0]]) * 26'(inv);
          mr   = 26'(PDM_AMP[amps_q[ch][7:5]][env_q[g].lev[7:4]]) * 26'(inv);
          pl_d = ml[24:16];
          pr_d = mr[24:16];
        end else begin
          ml   = 26'(amps_q[ch][3:0]) * 26'(mid_q);
          mr   = 26'(amps_q[ch][7:4]) * 26'(mid_q);
          pl_d = ml[20:12];
          pr_d = mr[20:12];
        end
      end
      CMD_DONE: begin
        out_valid_d       = 1'b1;
        out_d.read_data   = 8'd0;
        out_d.left_sample  = sat(suml_n);
        out_d.right_sample = sat(sumr_n);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_step_q   <= 18'h1_0000;
      edge_scale_q <= 18'h1_0000;
      for (int i = 0; i < 32; i++) reg_q[i] <= 8'd0;
      sel_q        <= 5'd0;
      out_on_q     <= 1'b0;
      sync_q       <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        phase_q[i]   <= 27'd0;
        period_q[i]  <= 9'd511;
        oct_now_q[i] <= 3'd0;
        oct_nxt_q[i] <= 3'd0;
        off_now_q[i] <= 8'd0;
        off_nxt_q[i] <= 8'd0;
        amps_q[i]    <= 8'd0;
        mix_q[i]     <= 2'd0;
      end
      level_q    <= '1;
      pend_new_q <= '0;
      pend_def_q <= '0;
      for (int i = 0; i < 2; i++) begin
        nsel_q[i]   <= 2'd0;
        ncnt_q[i]   <= 19'd0;
        nshift_q[i] <= '1;
        env_q[i]    <= ENV_RST;
      end
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clk_step_q   <= clk_step_d;
      edge_scale_q <= edge_scale_d;
      reg_q        <= reg_d;
      sel_q        <= sel_d;
      out_on_q     <= out_on_d;
      sync_q       <= sync_d;
      phase_q      <= phase_d;
      level_q      <= level_d;
      period_q     <= period_d;
      oct_now_q    <= oct_now_d;
      oct_nxt_q    <= oct_nxt_d;
      off_now_q    <= off_now_d;
      off_nxt_q    <= off_nxt_d;
      pend_new_q   <= pend_new_d;
      pend_def_q   <= pend_def_d;
      amps_q       <= amps_d;
      mix_q        <= mix_d;
      nsel_q       <= nsel_d;
      ncnt_q       <= ncnt_d;
      nshift_q     <= nshift_d;
      env_q        <= env_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    acc_q   <= acc_d;
    tprev_q <= tprev_d;
    oct_q   <= oct_d;
    mula_q  <= mula_d;
    rem_q   <= rem_d;
    mid_q   <= mid_d;
    pl_q    <= pl_d;
    pr_q    <= pr_d;
    suml_q  <= suml_d;
    sumr_q  <= sumr_d;
    out_q   <= out_d;
  end

endmodule

// File: sv/six_channel_sound_generator_unit.sv
// Top level of the six-channel sound generator: sequencer plus datapath.
//
// Usage: each input request is a bus select, a data write, a register read
// or one sample tick; each produces exactly one result on the output channel
// (read byte or stereo sample pair, the other fields zero). Both channels use
// valid/stall; the config port (clock_step at index 0, edge_scale at index 1)
// is always ready; the user must write it only while the block is idle, and
// the block does not enforce this. Timing: one request at a time. A bus
// request or muted tick passes the dispatch and bus states, and the bus state
// loads its result. An active sample tick steps both noise counters, once per
// counter wrap, then the shared tone unit visits the six channels in turn;
// each tone edge in the sample runs one pass of the shared edge multiplier.
// Reset clears all generator state at once; no item is accepted until the
// result of the previous one is loaded into the output register. When the
// receiver stalls, the result holds in that register while a new request
// may still be accepted and processed; it waits before its own result.
module six_channel_sound_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sgu_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sgu_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [17:0]        cfg_data_i
);
  import sgu_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sgu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  sgu_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.read_data == 8'd0) ||
                    (out_data_o.left_sample == 8'd0 && out_data_o.right_sample == 8'd0))
    else $error("read data and sample both nonzero");

  a_result_takes_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 in_stall_o)
    else $error("request finished too early");

endmodule
